/* rtl/hnad_pkg.sv */
// shared types, color tables and helpers for the hi-res artifact decoder
package hnad_pkg;

    localparam int unsigned WORD_W   = 14;
    localparam int unsigned WIN_W    = 31;
    localparam int unsigned COL_W    = 6;
    localparam int unsigned RGB_W    = 24;
    localparam int unsigned NUM_SUB  = 14;
    localparam int unsigned NUM_PIX  = 7;

    // one pending decode job: column, 31-bit sub-pixel window, line end flag
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [WIN_W-1:0] win;
        logic             last;
    } hnad_job_t;

    typedef logic [RGB_W-1:0] hnad_rgb_t;

    // artifact color table indexed by a 7 sub-pixel window
    localparam logic [7:0] ARTIFACT_TAB [128] = '{
        8'h00,8'h00,8'h00,8'h00,8'h88,8'h00,8'hcc,8'h00,
        8'h11,8'h11,8'h55,8'h11,8'h99,8'h99,8'hdd,8'hff,
        8'h22,8'h22,8'h66,8'h66,8'haa,8'haa,8'hee,8'hee,
        8'h33,8'h33,8'h33,8'h33,8'hbb,8'hbb,8'hff,8'hff,
        8'h00,8'h00,8'h44,8'h44,8'hcc,8'hcc,8'hcc,8'hcc,
        8'h55,8'h55,8'h55,8'h55,8'h99,8'h99,8'hdd,8'hff,
        8'h66,8'h22,8'h66,8'h66,8'hee,8'haa,8'hee,8'hee,
        8'h77,8'h77,8'h77,8'h77,8'hff,8'hff,8'hff,8'hff,
        8'h00,8'h00,8'h00,8'h00,8'h88,8'h88,8'h88,8'h88,
        8'h11,8'h11,8'h55,8'h11,8'h99,8'h99,8'hdd,8'h99,
        8'h00,8'h22,8'h66,8'h66,8'haa,8'haa,8'haa,8'haa,
        8'h33,8'h33,8'h33,8'h33,8'hbb,8'hbb,8'hff,8'hff,
        8'h00,8'h00,8'h44,8'h44,8'hcc,8'hcc,8'hcc,8'hcc,
        8'h11,8'h11,8'h55,8'h55,8'h99,8'h99,8'hdd,8'hdd,
        8'h00,8'h22,8'h66,8'h66,8'hee,8'haa,8'hee,8'hee,
        8'hff,8'h33,8'hff,8'h77,8'hff,8'hff,8'hff,8'hff
    };

    // palette packed as blue, green, red (red in the low byte)
    localparam hnad_rgb_t PALETTE_TAB [16] = '{
        24'h000000, 24'h400ba7, 24'hf71c40, 24'hff28e6,
        24'h407400, 24'h808080, 24'hff9019, 24'hff9cbf,
        24'h006340, 24'h006fe6, 24'h808080, 24'hbf8bff,
        24'h00d719, 24'h08e3bf, 24'hbff458, 24'hffffff
    };

    // double seven dots into 14 sub-pixels, optional half-dot delay
    function automatic logic [WORD_W-1:0] make_word(input logic [7:0] b, input logic carry);
        logic [WORD_W-1:0] w;
        begin
            for (int j = 0; j < 7; j++) begin
                w[2*j]   = b[j];
                w[2*j+1] = b[j];
            end
            if (b[7]) begin
                w = {w[WORD_W-2:0], carry};
            end
            return w;
        end
    endfunction

    // average two palette entries per channel, rounded down
    function automatic hnad_rgb_t mix(input logic [3:0] ia, input logic [3:0] ib);
        hnad_rgb_t a;
        hnad_rgb_t b;
        logic [8:0] sr;
        logic [8:0] sg;
        logic [8:0] sb;
        begin
            a  = PALETTE_TAB[ia];
            b  = PALETTE_TAB[ib];
            sr = {1'b0, a[7:0]}   + {1'b0, b[7:0]};
            sg = {1'b0, a[15:8]}  + {1'b0, b[15:8]};
            sb = {1'b0, a[23:16]} + {1'b0, b[23:16]};
            return {sb[8:1], sg[8:1], sr[8:1]};
        end
    endfunction

endpackage

/* rtl/hnad_word_track.sv */
// line state, sub-pixel word build and decode job queue
module hnad_word_track #(
    parameter int unsigned BYTES_PER_LINE = 40
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_hires_byte,
    input  logic               job_take,
    output logic               job_valid,
    output hnad_pkg::hnad_job_t job
);
    import hnad_pkg::*;

    localparam logic [COL_W:0] LAST_LIMIT = (COL_W+1)'(BYTES_PER_LINE);

    logic [COL_W-1:0]  col_reg,  col_next;
    logic [WORD_W-1:0] prev_reg, prev_next;
    logic [WORD_W-1:0] pend_reg, pend_next;
    logic              job_valid_reg, job_valid_next;
    hnad_job_t         job_reg, job_next;
    logic              extra_valid_reg, extra_valid_next;
    hnad_job_t         extra_reg, extra_next;

    logic              accept;
    logic              job_free;
    logic              has_left;
    logic              is_last;
    logic [WORD_W-1:0] word_cur;
    logic [WORD_W-1:0] wp_a;
    logic [WORD_W-1:0] wp_b;
    hnad_job_t         job_a;
    hnad_job_t         job_b;

    // handshake: one slot ahead of the decoder plus a spare for the line end
    assign job_free = !job_valid_reg || job_take;
    assign s_ready  = !extra_valid_reg && job_free;
    assign accept   = s_valid && s_ready;

    // word of the incoming byte and the jobs it releases
    always_comb begin
        has_left = (col_reg != '0);
        is_last  = ({1'b0, col_reg} + 1'b1) >= LAST_LIMIT;
        word_cur = make_word(s_hires_byte, has_left & pend_reg[WORD_W-1]);
        wp_a     = (col_reg > COL_W'(1)) ? prev_reg : '0;
        wp_b     = has_left ? pend_reg : '0;
        job_a.col  = col_reg - 1'b1;
        job_a.win  = {word_cur, pend_reg, wp_a[WORD_W-1:WORD_W-3]};
        job_a.last = 1'b0;
        job_b.col  = col_reg;
        job_b.win  = {{WORD_W{1'b0}}, word_cur, wp_b[WORD_W-1:WORD_W-3]};
        job_b.last = 1'b1;
    end

    // line state update
    always_comb begin
        col_next  = col_reg;
        prev_next = prev_reg;
        pend_next = pend_reg;
        if (accept) begin
            if (is_last) begin
                col_next  = '0;
                prev_next = '0;
                pend_next = '0;
            end else begin
                col_next  = col_reg + 1'b1;
                prev_next = has_left ? pend_reg : '0;
                pend_next = word_cur;
            end
        end
    end

    // job slot and spare slot
    always_comb begin
        job_valid_next   = job_valid_reg;
        job_next         = job_reg;
        extra_valid_next = extra_valid_reg;
        extra_next       = extra_reg;
        if (job_free) begin
            job_valid_next = 1'b0;
        end
        if (extra_valid_reg && job_free) begin
            job_valid_next   = 1'b1;
            job_next         = extra_reg;
            extra_valid_next = 1'b0;
        end else if (accept) begin
            if (has_left) begin
                job_valid_next   = 1'b1;
                job_next         = job_a;
                extra_valid_next = is_last;
                extra_next       = job_b;
            end else if (is_last) begin
                job_valid_next = 1'b1;
                job_next       = job_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            prev_reg        <= '0;
            pend_reg        <= '0;
            job_valid_reg   <= 1'b0;
            extra_valid_reg <= 1'b0;
        end else begin
            col_reg         <= col_next;
            prev_reg        <= prev_next;
            pend_reg        <= pend_next;
            job_valid_reg   <= job_valid_next;
            extra_valid_reg <= extra_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        extra_reg <= extra_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

/* rtl/hnad_pixel_decode.sv */
// artifact lookup, palette mix and output register
module hnad_pixel_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  hnad_pkg::hnad_job_t job,
    output logic                job_take,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [5:0]          m_byte_column,
    output logic [23:0]         m_pixel_zero,
    output logic [23:0]         m_pixel_one,
    output logic [23:0]         m_pixel_two,
    output logic [23:0]         m_pixel_three,
    output logic [23:0]         m_pixel_four,
    output logic [23:0]         m_pixel_five,
    output logic [23:0]         m_pixel_six,
    output logic                m_line_end
);
    import hnad_pkg::*;

    logic              m_valid_reg, m_valid_next;
    logic [COL_W-1:0]  col_reg;
    hnad_rgb_t         pix_reg [NUM_PIX];
    logic              last_reg;

    logic [3:0]        sub_idx [NUM_SUB];
    hnad_rgb_t         pix_cur [NUM_PIX];

    // per sub-pixel table lookup rotated by absolute position
    always_comb begin
        logic [1:0] pos2;
        logic [1:0] rot;
        logic [7:0] lut;
        for (int s = 0; s < NUM_SUB; s++) begin
            pos2 = {job.col[0], 1'b0} + 2'(s);
            rot  = 2'b00 - pos2;
            lut  = ARTIFACT_TAB[job.win[s +: 7]];
            sub_idx[s] = 4'(lut >> rot);
        end
    end

    // pixel colors from sub-pixel pairs
    always_comb begin
        for (int k = 0; k < NUM_PIX; k++) begin
            pix_cur[k] = mix(sub_idx[2*k], sub_idx[2*k+1]);
        end
    end

    // output register
    assign job_take     = !m_valid_reg || m_ready;
    assign m_valid_next = job_take ? job_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_take && job_valid) begin
            col_reg  <= job.col;
            pix_reg  <= pix_cur;
            last_reg <= job.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_byte_column = col_reg;
    assign m_pixel_zero  = pix_reg[0];
    assign m_pixel_one   = pix_reg[1];
    assign m_pixel_two   = pix_reg[2];
    assign m_pixel_three = pix_reg[3];
    assign m_pixel_four  = pix_reg[4];
    assign m_pixel_five  = pix_reg[5];
    assign m_pixel_six   = pix_reg[6];
    assign m_line_end    = last_reg;

endmodule

/* rtl/hires_ntsc_artifact_scanline_decode_unit.sv */
// top level of the hi-res NTSC artifact color scanline decoder
//
// Input channel s_*: one scanline byte per word, BYTES_PER_LINE bytes per line.
// Bits 0-6 are dots (bit 0 leftmost), bit 7 delays the byte by half a dot.
// Output channel m_*: one word per byte with its column, seven RGB pixels
// (red in bits 7:0, green 15:8, blue 23:16) and line_end on the last byte.
// A byte's result needs the next byte as right context, so it leaves when
// the next byte is taken: the first byte of a line gives nothing, the last
// gives two words (its neighbor's, then its own with line_end set).
// A result passes through the job register and then the output register
// before m_valid shows it (one job register, one output register).
// Throughput: one byte per cycle while m_ready is high; the line-end byte
// releases two jobs, so s_ready drops for one cycle as the spare slot drains.
// When m_ready is low the output register holds and s_ready falls once the
// job slot behind it is full; no word is lost or repeated.
// Reset (aresetn low, synchronous) clears the column count, the stored
// words and all valid flags; the block starts at column zero.
module hires_ntsc_artifact_scanline_decode_unit #(
    parameter int unsigned BYTES_PER_LINE = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_hires_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_byte_column,
    output logic [23:0] m_pixel_zero,
    output logic [23:0] m_pixel_one,
    output logic [23:0] m_pixel_two,
    output logic [23:0] m_pixel_three,
    output logic [23:0] m_pixel_four,
    output logic [23:0] m_pixel_five,
    output logic [23:0] m_pixel_six,
    output logic        m_line_end
);
    import hnad_pkg::*;

    logic      job_valid;
    logic      job_take;
    hnad_job_t job;

    // line tracking and job generation
    hnad_word_track #(
        .BYTES_PER_LINE(BYTES_PER_LINE)
    ) u_word_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hires_byte(s_hires_byte),
        .job_take    (job_take),
        .job_valid   (job_valid),
        .job         (job)
    );

    // color decode and output register
    hnad_pixel_decode u_pixel_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (job_valid),
        .job          (job),
        .job_take     (job_take),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte_column(m_byte_column),
        .m_pixel_zero (m_pixel_zero),
        .m_pixel_one  (m_pixel_one),
        .m_pixel_two  (m_pixel_two),
        .m_pixel_three(m_pixel_three),
        .m_pixel_four (m_pixel_four),
        .m_pixel_five (m_pixel_five),
        .m_pixel_six  (m_pixel_six),
        .m_line_end   (m_line_end)
    );

endmodule

/* tb/sv/hnad_scanline_sb_pkg.sv */
// scoreboard with its own artifact color decoder for the scanline decode testbench
package hnad_scanline_sb_pkg;

    // seven pixels of one byte column, pix[0] leftmost
    typedef struct packed {
        logic [5:0]        col;
        logic [6:0][23:0]  pix;
        logic              last;
    } column_pixels_t;

    // color of each 7 sub-pixel neighborhood, two nibbles per entry
    localparam logic [7:0] SUB_COLOR_TAB [128] = '{
        8'h00,8'h00,8'h00,8'h00,8'h88,8'h00,8'hcc,8'h00,
        8'h11,8'h11,8'h55,8'h11,8'h99,8'h99,8'hdd,8'hff,
        8'h22,8'h22,8'h66,8'h66,8'haa,8'haa,8'hee,8'hee,
        8'h33,8'h33,8'h33,8'h33,8'hbb,8'hbb,8'hff,8'hff,
        8'h00,8'h00,8'h44,8'h44,8'hcc,8'hcc,8'hcc,8'hcc,
        8'h55,8'h55,8'h55,8'h55,8'h99,8'h99,8'hdd,8'hff,
        8'h66,8'h22,8'h66,8'h66,8'hee,8'haa,8'hee,8'hee,
        8'h77,8'h77,8'h77,8'h77,8'hff,8'hff,8'hff,8'hff,
        8'h00,8'h00,8'h00,8'h00,8'h88,8'h88,8'h88,8'h88,
        8'h11,8'h11,8'h55,8'h11,8'h99,8'h99,8'hdd,8'h99,
        8'h00,8'h22,8'h66,8'h66,8'haa,8'haa,8'haa,8'haa,
        8'h33,8'h33,8'h33,8'h33,8'hbb,8'hbb,8'hff,8'hff,
        8'h00,8'h00,8'h44,8'h44,8'hcc,8'hcc,8'hcc,8'hcc,
        8'h11,8'h11,8'h55,8'h55,8'h99,8'h99,8'hdd,8'hdd,
        8'h00,8'h22,8'h66,8'h66,8'hee,8'haa,8'hee,8'hee,
        8'hff,8'h33,8'hff,8'h77,8'hff,8'hff,8'hff,8'hff
    };

    // sixteen colors written as red, green, blue from the top byte down
    localparam logic [23:0] COLOR_RRGGBB [16] = '{
        24'h000000, 24'ha70b40, 24'h401cf7, 24'he628ff,
        24'h007440, 24'h808080, 24'h1990ff, 24'hbf9cff,
        24'h406300, 24'he66f00, 24'h808080, 24'hff8bbf,
        24'h19d700, 24'hbfe308, 24'h58f4bf, 24'hffffff
    };

    class scanline_scoreboard;
        column_pixels_t pixel_words_due[$];
        int unsigned    errors;
        int unsigned    words_checked;
        int unsigned    bytes_per_line;
        logic [5:0]     col_cnt;
        logic [13:0]    prev_word;
        logic [13:0]    pend_word;

        function new(int unsigned bpl);
            bytes_per_line = bpl;
            errors         = 0;
            words_checked  = 0;
            col_cnt        = '0;
            prev_word      = '0;
            pend_word      = '0;
        endfunction

        function int unsigned depth();
            return pixel_words_due.size();
        endfunction

        // doubled dots, shifted up one sub-pixel when the half-dot bit is set
        function logic [13:0] spread_dots(logic [7:0] b, logic carry);
            logic [13:0] w;
            for (int j = 0; j < 7; j++) begin
                w[2*j]   = b[j];
                w[2*j+1] = b[j];
            end
            if (b[7]) begin
                w = {w[12:0], carry};
            end
            return w;
        endfunction

        // per-channel average of two colors, rounded down, blue on top
        function logic [23:0] blend(logic [3:0] ia, logic [3:0] ib);
            logic [23:0] ca;
            logic [23:0] cb;
            logic [8:0]  sr;
            logic [8:0]  sg;
            logic [8:0]  sbl;
            ca  = COLOR_RRGGBB[ia];
            cb  = COLOR_RRGGBB[ib];
            sr  = {1'b0, ca[23:16]} + {1'b0, cb[23:16]};
            sg  = {1'b0, ca[15:8]}  + {1'b0, cb[15:8]};
            sbl = {1'b0, ca[7:0]}   + {1'b0, cb[7:0]};
            return {sbl[8:1], sg[8:1], sr[8:1]};
        endfunction

        // slide the window across one column and rotate by absolute position
        function column_pixels_t decode_column(logic [5:0] col, logic [13:0] wp,
                                               logic [13:0] wc, logic [13:0] wn,
                                               logic last);
            column_pixels_t r;
            logic [30:0]    win;
            logic [3:0]     idx [14];
            logic [7:0]     lut;
            int unsigned    pos;
            win = {wn, wc, wp[13:11]};
            for (int s = 0; s < 14; s++) begin
                pos    = int'(col) * 14 + s;
                lut    = SUB_COLOR_TAB[win[6:0]];
                idx[s] = 4'(lut >> ((4 - pos % 4) % 4));
                win    = win >> 1;
            end
            r.col  = col;
            r.last = last;
            for (int k = 0; k < 7; k++) begin
                r.pix[k] = blend(idx[2*k], idx[2*k+1]);
            end
            return r;
        endfunction

        // accepted byte: advance the line state and queue the words it releases
        function void note_byte(logic [7:0] b);
            logic [5:0]  col;
            logic        carry;
            logic [13:0] w;
            col   = col_cnt;
            carry = (col > 0) ? pend_word[13] : 1'b0;
            w     = spread_dots(b, carry);
            if (col > 0) begin
                pixel_words_due.push_back(decode_column(col - 6'd1,
                    (col > 1) ? prev_word : 14'd0, pend_word, w, 1'b0));
                prev_word = pend_word;
            end else begin
                prev_word = '0;
            end
            pend_word = w;
            // last byte of the line flushes with zero right context
            if (int'(col) + 1 >= int'(bytes_per_line)) begin
                pixel_words_due.push_back(decode_column(col,
                    (col > 0) ? prev_word : 14'd0, pend_word, 14'd0, 1'b1));
                col_cnt   = '0;
                prev_word = '0;
                pend_word = '0;
            end else begin
                col_cnt = col + 6'd1;
            end
        endfunction

        task report_mismatch(string msg);
            if (errors < 40) begin
                $display("mismatch: %s", msg);
            end
            errors++;
        endtask

        // accepted output word against the oldest expected one
        task check_word(logic [5:0] col, logic [6:0][23:0] pix, logic last);
            column_pixels_t exp_w;
            if (pixel_words_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word for column %0d", col));
                return;
            end
            exp_w = pixel_words_due.pop_front();
            words_checked++;
            if (col !== exp_w.col) begin
                report_mismatch($sformatf("byte_column %0d, want %0d", col, exp_w.col));
            end
            for (int k = 0; k < 7; k++) begin
                if (pix[k] !== exp_w.pix[k]) begin
                    report_mismatch($sformatf("column %0d pixel %0d got %06h want %06h",
                                              exp_w.col, k, pix[k], exp_w.pix[k]));
                end
            end
            if (last !== exp_w.last) begin
                report_mismatch($sformatf("column %0d line_end %0b want %0b",
                                          exp_w.col, last, exp_w.last));
            end
        endtask
    endclass

endpackage

/* tb/sv/hires_ntsc_artifact_scanline_decode_unit_tb.sv */
// top of the scanline decode testbench: clock, reset, byte driver and word checker
module hires_ntsc_artifact_scanline_decode_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hnad_scanline_sb_pkg::*;

    localparam int unsigned BPL       = 40;
    localparam int unsigned NUM_LINES = 22;

    // opening bytes: dot extremes, half-dot shifts and carry patterns
    localparam logic [7:0] OPENING [25] = '{
        8'h00, 8'hFF, 8'h7F, 8'h80, 8'h81, 8'hFF, 8'h80, 8'h55, 8'hAA,
        8'hD5, 8'hAA, 8'h2A, 8'h01, 8'h40, 8'hC0, 8'h7F, 8'hFF, 8'h80,
        8'h00, 8'h80, 8'h01, 8'h81, 8'h03, 8'h60, 8'hE0
    };

    localparam logic [7:0] CORNER_BYTES [12] = '{
        8'h00, 8'hFF, 8'h7F, 8'h80, 8'h55, 8'hAA, 8'hD5, 8'h2A,
        8'h01, 8'h40, 8'h81, 8'hC0
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_hires_byte;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_byte_column;
    logic [23:0] m_pixel_zero;
    logic [23:0] m_pixel_one;
    logic [23:0] m_pixel_two;
    logic [23:0] m_pixel_three;
    logic [23:0] m_pixel_four;
    logic [23:0] m_pixel_five;
    logic [23:0] m_pixel_six;
    logic        m_line_end;

    scanline_scoreboard sb;
    bit          tx_calm;
    bit          rx_calm;
    int unsigned bytes_sent;

    hires_ntsc_artifact_scanline_decode_unit #(
        .BYTES_PER_LINE(BPL)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_hires_byte(s_hires_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_byte_column(m_byte_column),
        .m_pixel_zero(m_pixel_zero),
        .m_pixel_one(m_pixel_one),
        .m_pixel_two(m_pixel_two),
        .m_pixel_three(m_pixel_three),
        .m_pixel_four(m_pixel_four),
        .m_pixel_five(m_pixel_five),
        .m_pixel_six(m_pixel_six),
        .m_line_end(m_line_end)
    );

    always #4 aclk = ~aclk;

    function automatic int unsigned draw_wait(bit calm);
        if (calm || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(1, 12);
    endfunction

    // mostly random bytes, with corner patterns, runs and half-dot flips
    function automatic logic [7:0] pick_byte(logic [7:0] prev_b);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel <= 4) begin
            return 8'($urandom_range(0, 255));
        end else if (sel <= 6) begin
            return CORNER_BYTES[$urandom_range(0, 11)];
        end else if (sel == 7) begin
            return prev_b;
        end else if (sel == 8) begin
            return prev_b ^ 8'h80;
        end
        return {1'($urandom_range(0, 1)), ($urandom_range(0, 1) != 0) ? 7'h7F : 7'h00};
    endfunction

    // one input word; hold drains every expected word before raising valid
    task automatic send_byte(input logic [7:0] b, input int unsigned gap, input bit hold);
        if (gap > 0 || hold) begin
            s_valid <= 1'b0;
            if (hold) begin
                @(posedge aclk);
                while (sb.depth() != 0) @(posedge aclk);
            end
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_hires_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // stimulus: one directed line, then random lines
    initial begin
        logic [7:0] b;
        bit         hold;
        int unsigned guard;
        sb           = new(BPL);
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_hires_byte = '0;
        m_ready      = 1'b0;
        bytes_sent   = 0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        b            = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ln = 0; ln < NUM_LINES; ln++) begin
            tx_calm = (ln % 5 == 2);
            rx_calm = (ln % 4 == 1) || tx_calm;
            for (int c = 0; c < BPL; c++) begin
                if (ln == 0 && c < 25) begin
                    b = OPENING[c];
                end else if (ln == 0 && c == BPL - 1) begin
                    // bit 13 set at line end, next line must not carry it in
                    b = 8'hFF;
                end else if (c == 0 && (ln == 1 || $urandom_range(0, 1) != 0)) begin
                    b = 8'h80 | 8'($urandom_range(0, 127));
                end else begin
                    b = pick_byte(b);
                end
                hold = ((ln % 6 == 3) && c == BPL / 2) || (ln == 8 && c == 0);
                send_byte(b, tx_calm ? 0 : draw_wait(1'b0), hold);
            end
        end
        s_valid <= 1'b0;

        // drain, then keep watching for any stray word
        guard = 0;
        while (sb.depth() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (16) @(posedge aclk);
        if (sb.depth() != 0) begin
            sb.report_mismatch($sformatf("%0d expected words never arrived", sb.depth()));
        end

        $display("covered %0d lines of %0d bytes (%0d bytes), %0d words checked",
                 NUM_LINES, BPL, bytes_sent, sb.words_checked);
        $display("with random gaps and stalls on both sides and drain pauses mid-line");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // output side: random stall before each word, then take it and check
    initial begin
        int unsigned w;
        wait (aresetn === 1'b1);
        forever begin
            w = draw_wait(rx_calm);
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_word(m_byte_column,
                          {m_pixel_six, m_pixel_five, m_pixel_four, m_pixel_three,
                           m_pixel_two, m_pixel_one, m_pixel_zero},
                          m_line_end);
        end
    end

    // watchdog
    initial begin
        #(5_000_000);
        $display("timeout waiting for the decoder");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
